/* hdl/paa_pkg.sv */
package paa_pkg;

  // default number of attractor slots
  localparam int NUM_ATTR_DEF = 4;
  // slots that own a configuration register
  localparam int ATT_REGS = 4;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam logic [CFG_IDX_W-1:0] REG_ATT_COUNT = 3'd4;
  localparam int COUNT_W = 3;

  // arithmetic widths
  localparam int COMP_W  = 16;             // Q8.8 component
  localparam int OFS_W   = COMP_W + 1;     // attractor minus position
  localparam int SQ_W    = 32;             // one squared offset
  localparam int LEN_W   = SQ_W + 2;       // sum of four squares
  localparam int PROD_W  = OFS_W + COMP_W; // offset times strength
  localparam int MAG_W   = PROD_W - 1;     // magnitude of that product
  localparam int FRAC_W  = 16;             // Q16.16 shift of the dividend
  localparam int REM_W   = LEN_W + 1;      // partial remainder
  localparam int DIV_STEPS = MAG_W;        // one quotient bit per stage
  localparam int ACC_W   = 32;
  localparam int TERM_W  = MAG_W + 1;

  typedef struct packed {
    logic signed [COMP_W-1:0] pos_x;
    logic signed [COMP_W-1:0] pos_y;
    logic signed [COMP_W-1:0] pos_z;
    logic signed [COMP_W-1:0] pos_w;
    logic signed [ACC_W-1:0]  acc_x;
    logic signed [ACC_W-1:0]  acc_y;
    logic signed [ACC_W-1:0]  acc_z;
    logic signed [ACC_W-1:0]  acc_w;
    logic                     last_particle;
  } in_word_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] new_acc_x;
    logic signed [ACC_W-1:0] new_acc_y;
    logic signed [ACC_W-1:0] new_acc_z;
    logic signed [ACC_W-1:0] new_acc_w;
    logic                    frame_end;
  } out_word_t;

endpackage

/* hdl/paa_if.sv */
// particle input channel
interface paa_in_if;
  logic               valid;
  logic               ready;
  paa_pkg::in_word_t  data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// acceleration result channel
interface paa_out_if;
  logic               valid;
  logic               ready;
  paa_pkg::out_word_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

/* hdl/point_attractor_accel.sv */
// Point attractor acceleration pipeline. One particle word is accepted per clock while the
// output is not stalled, and one result word leaves per particle, in order. Three stages
// form offsets, squares and products, 32 stages run a bit-per-stage divider for every slot
// and component in parallel, one stage signs the terms, and one saturating add stage per
// slot (in slot order) ends in the output register. The whole pipe holds when the output
// word is not taken. Attractor and count registers are read by the first three stages,
// so write them only while no word is in the pipe; nothing needs clearing after reset.
module point_attractor_accel #(
  parameter int NUM_ATTRACTORS = paa_pkg::NUM_ATTR_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [paa_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [paa_pkg::CFG_DATA_W-1:0]  cfg_data,
  paa_in_if.sink                          in_ch,
  paa_out_if.source                       out_ch
);
  import paa_pkg::*;

  localparam int NA = NUM_ATTRACTORS;

  function automatic logic signed [ACC_W-1:0] sat_add(
    input logic signed [ACC_W-1:0]  a,
    input logic signed [TERM_W-1:0] t
  );
    logic signed [ACC_W+1:0] s;
    s = (ACC_W+2)'(a) + (ACC_W+2)'(t);
    if (s > (ACC_W+2)'(2147483647)) return {1'b0, {(ACC_W-1){1'b1}}};
    if (s < -(ACC_W+2)'(64'sd2147483648)) return {1'b1, {(ACC_W-1){1'b0}}};
    return s[ACC_W-1:0];
  endfunction

  // configuration registers
  logic [CFG_DATA_W-1:0] att_r [NA];
  logic [COUNT_W-1:0]    count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NA; k++) att_r[k] <= '0;
      count_r <= '0;
    end else if (cfg_we) begin
      for (int k = 0; k < NA; k++) begin
        if (k < ATT_REGS && cfg_idx == CFG_IDX_W'(k)) att_r[k] <= cfg_data;
      end
      if (cfg_idx == REG_ATT_COUNT) count_r <= cfg_data[COUNT_W-1:0];
    end
  end

  logic adv;
  logic signed [ACC_W-1:0] acc_in [4];
  logic signed [COMP_W-1:0] pos_in [4];

  assign acc_in[0] = in_ch.data.acc_x;
  assign acc_in[1] = in_ch.data.acc_y;
  assign acc_in[2] = in_ch.data.acc_z;
  assign acc_in[3] = in_ch.data.acc_w;
  assign pos_in[0] = in_ch.data.pos_x;
  assign pos_in[1] = in_ch.data.pos_y;
  assign pos_in[2] = in_ch.data.pos_z;
  assign pos_in[3] = in_ch.data.pos_w;

  // stage 1: offsets
  logic                     v1_r;
  logic                     last1_r;
  logic signed [ACC_W-1:0]  acc1_r [4];
  logic signed [OFS_W-1:0]  d1_r [NA][4];

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (adv) v1_r <= in_ch.valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      last1_r <= in_ch.data.last_particle;
      for (int c = 0; c < 4; c++) begin
        acc1_r[c] <= acc_in[c];
        for (int k = 0; k < NA; k++) begin
          d1_r[k][c] <= OFS_W'($signed(att_r[k][COMP_W*c +: COMP_W])) - OFS_W'(pos_in[c]);
        end
      end
    end
  end

  // stage 2: squares and offset times strength
  logic                     v2_r;
  logic                     last2_r;
  logic signed [ACC_W-1:0]  acc2_r [4];
  logic [SQ_W-1:0]          sq2_r [NA][4];
  logic signed [PROD_W-1:0] prod2_r [NA][4];

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (adv) v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    logic signed [2*OFS_W-1:0] sq_full;
    logic signed [COMP_W-1:0]  str;
    if (adv) begin
      last2_r <= last1_r;
      for (int c = 0; c < 4; c++) begin
        acc2_r[c] <= acc1_r[c];
        for (int k = 0; k < NA; k++) begin
          str = $signed(att_r[k][CFG_DATA_W-1 -: COMP_W]);
          sq_full = d1_r[k][c] * d1_r[k][c];
          sq2_r[k][c] <= sq_full[SQ_W-1:0];
          prod2_r[k][c] <= PROD_W'(d1_r[k][c]) * PROD_W'(str);
        end
      end
    end
  end

  // stage 3: squared length, magnitudes, slot enables
  logic                     v3_r;
  logic                     last3_r;
  logic signed [ACC_W-1:0]  acc3_r [4];
  logic [LEN_W-1:0]         len3_r [NA];
  logic [MAG_W-1:0]         mag3_r [NA][4];
  logic                     neg3_r [NA][4];
  logic                     en3_r [NA];

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (adv) v3_r <= v2_r;
  end

  always_ff @(posedge clk) begin
    logic [LEN_W-1:0]         len;
    logic signed [PROD_W-1:0] neg_prod;
    if (adv) begin
      last3_r <= last2_r;
      for (int c = 0; c < 4; c++) acc3_r[c] <= acc2_r[c];
      for (int k = 0; k < NA; k++) begin
        len = LEN_W'(sq2_r[k][0]) + LEN_W'(sq2_r[k][1]) +
              LEN_W'(sq2_r[k][2]) + LEN_W'(sq2_r[k][3]);
        len3_r[k] <= len;
        en3_r[k] <= (int'(count_r) > k) && (len != '0);
        for (int c = 0; c < 4; c++) begin
          neg_prod = -prod2_r[k][c];
          neg3_r[k][c] <= prod2_r[k][c][PROD_W-1];
          mag3_r[k][c] <= prod2_r[k][c][PROD_W-1] ? neg_prod[MAG_W-1:0]
                                                  : prod2_r[k][c][MAG_W-1:0];
        end
      end
    end
  end

  // dividers, one per slot and component
  logic [MAG_W-1:0] quot [NA][4];

  for (genvar k = 0; k < NA; k++) begin : g_slot
    for (genvar c = 0; c < 4; c++) begin : g_comp
      paa_div u_div (
        .clk  (clk),
        .adv  (adv),
        .mag  (mag3_r[k][c]),
        .len  (len3_r[k]),
        .quot (quot[k][c])
      );
    end
  end

  // side data that travels beside the dividers
  logic                     vd_r [DIV_STEPS];
  logic                     lastd_r [DIV_STEPS];
  logic signed [ACC_W-1:0]  accd_r [DIV_STEPS][4];
  logic                     negd_r [DIV_STEPS][NA][4];
  logic                     end_r [DIV_STEPS][NA];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < DIV_STEPS; j++) vd_r[j] <= 1'b0;
    end else if (adv) begin
      vd_r[0] <= v3_r;
      for (int j = 1; j < DIV_STEPS; j++) vd_r[j] <= vd_r[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < DIV_STEPS; j++) begin
        lastd_r[j] <= (j == 0) ? last3_r : lastd_r[j-1];
        for (int c = 0; c < 4; c++) accd_r[j][c] <= (j == 0) ? acc3_r[c] : accd_r[j-1][c];
        for (int k = 0; k < NA; k++) begin
          end_r[j][k] <= (j == 0) ? en3_r[k] : end_r[j-1][k];
          for (int c = 0; c < 4; c++) begin
            negd_r[j][k][c] <= (j == 0) ? neg3_r[k][c] : negd_r[j-1][k][c];
          end
        end
      end
    end
  end

  // signed terms, zero for disabled slots
  logic                     vt_r;
  logic                     lastt_r;
  logic signed [ACC_W-1:0]  acct_r [4];
  logic signed [TERM_W-1:0] termt_r [NA][4];

  always_ff @(posedge clk) begin
    if (!rst_n) vt_r <= 1'b0;
    else if (adv) vt_r <= vd_r[DIV_STEPS-1];
  end

  always_ff @(posedge clk) begin
    logic signed [TERM_W-1:0] q;
    if (adv) begin
      lastt_r <= lastd_r[DIV_STEPS-1];
      for (int c = 0; c < 4; c++) acct_r[c] <= accd_r[DIV_STEPS-1][c];
      for (int k = 0; k < NA; k++) begin
        for (int c = 0; c < 4; c++) begin
          q = $signed({1'b0, quot[k][c]});
          if (!end_r[DIV_STEPS-1][k]) termt_r[k][c] <= '0;
          else termt_r[k][c] <= negd_r[DIV_STEPS-1][k][c] ? -q : q;
        end
      end
    end
  end

  // saturating accumulation, one slot per stage in slot order
  logic                     va_r [NA];
  logic                     lasta_r [NA];
  logic signed [ACC_W-1:0]  acca_r [NA][4];
  logic signed [TERM_W-1:0] terma_r [NA][NA][4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NA; s++) va_r[s] <= 1'b0;
    end else if (adv) begin
      va_r[0] <= vt_r;
      for (int s = 1; s < NA; s++) va_r[s] <= va_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int s = 0; s < NA; s++) begin
        lasta_r[s] <= (s == 0) ? lastt_r : lasta_r[s-1];
        for (int c = 0; c < 4; c++) begin
          if (s == 0) acca_r[s][c] <= sat_add(acct_r[c], termt_r[s][c]);
          else acca_r[s][c] <= sat_add(acca_r[s-1][c], terma_r[s-1][s][c]);
          for (int k = 0; k < NA; k++) begin
            terma_r[s][k][c] <= (s == 0) ? termt_r[k][c] : terma_r[s-1][k][c];
          end
        end
      end
    end
  end

  // handshake: the whole pipe moves unless the output word is held
  assign adv = !va_r[NA-1] || out_ch.ready;
  assign in_ch.ready = adv;

  assign out_ch.valid = va_r[NA-1];
  assign out_ch.data.new_acc_x = acca_r[NA-1][0];
  assign out_ch.data.new_acc_y = acca_r[NA-1][1];
  assign out_ch.data.new_acc_z = acca_r[NA-1][2];
  assign out_ch.data.new_acc_w = acca_r[NA-1][3];
  assign out_ch.data.frame_end = lasta_r[NA-1];

endmodule

/* hdl/paa_div.sv */
// Unsigned restoring divider, one quotient bit per stage.
// Computes (mag << FRAC_W) / len; the quotient must fit in MAG_W bits.
module paa_div (
  input  logic                        clk,
  input  logic                        adv,
  input  logic [paa_pkg::MAG_W-1:0]   mag,
  input  logic [paa_pkg::LEN_W-1:0]   len,
  output logic [paa_pkg::MAG_W-1:0]   quot
);
  import paa_pkg::*;

  logic [REM_W-1:0] rem_r [DIV_STEPS];
  logic [MAG_W-1:0] low_r [DIV_STEPS];
  logic [LEN_W-1:0] len_r [DIV_STEPS];

  logic [REM_W-1:0] rem_nxt [DIV_STEPS];
  logic [MAG_W-1:0] low_nxt [DIV_STEPS];

  // one compare and subtract per stage; quotient bits replace used dividend bits
  always_comb begin
    logic [REM_W-1:0] rem_in;
    logic [MAG_W-1:0] low_in;
    logic [LEN_W-1:0] len_in;
    logic [REM_W-1:0] trial;
    logic             ge;
    for (int j = 0; j < DIV_STEPS; j++) begin
      if (j == 0) begin
        rem_in = REM_W'(mag >> FRAC_W);
        low_in = MAG_W'(mag << FRAC_W);
        len_in = len;
      end else begin
        rem_in = rem_r[j-1];
        low_in = low_r[j-1];
        len_in = len_r[j-1];
      end
      trial = {rem_in[REM_W-2:0], low_in[MAG_W-1]};
      ge = (trial >= REM_W'(len_in));
      rem_nxt[j] = ge ? (trial - REM_W'(len_in)) : trial;
      low_nxt[j] = {low_in[MAG_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < DIV_STEPS; j++) begin
        rem_r[j] <= rem_nxt[j];
        low_r[j] <= low_nxt[j];
        len_r[j] <= (j == 0) ? len : len_r[j-1];
      end
    end
  end

  assign quot = low_r[DIV_STEPS-1];

endmodule

/* hdl/paa_chk.sv */
module paa_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input paa_pkg::out_word_t         out_data
);
  import paa_pkg::*;

  // a held result word stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // a held result word keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result word changed while stalled");

  // the input side only stalls behind a held result
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

  // reset empties the pipe
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word valid after reset");

  // no word comes out of an empty pipe in the cycle after reset releases
  a_no_early: assert property (@(posedge clk)
    !rst_n ##1 rst_n |-> !out_valid && in_ready)
    else $error("pipe not empty after reset");

endmodule

bind point_attractor_accel paa_chk u_paa_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

/* sim/point_attractor_accel_check.sv */
`timescale 1ns / 100ps

// Watches both channels and the register port, predicts each result word
// from the accepted particle word and compares it with what comes out.
module point_attractor_accel_check (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [paa_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [paa_pkg::CFG_DATA_W-1:0] cfg_data,
  paa_in_if                              in_ch,
  paa_out_if                             out_ch,
  output int                             fails,
  output int                             pending
);
  import paa_pkg::*;

  localparam int SLOTS = 4;

  logic [CFG_DATA_W-1:0] att_slot [SLOTS];
  logic [COUNT_W-1:0]    att_used;
  out_word_t             acc_due [$];

  function automatic longint sat_acc(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // sum of attractor pulls on one particle
  function automatic out_word_t attractor_pull(in_word_t w);
    longint pos [4];
    longint acc [4];
    longint att [4];
    longint ofs [4];
    longint len2, strength;
    logic signed [COMP_W-1:0] comp;
    int used;
    out_word_t r;
    pos[0] = w.pos_x; pos[1] = w.pos_y; pos[2] = w.pos_z; pos[3] = w.pos_w;
    acc[0] = w.acc_x; acc[1] = w.acc_y; acc[2] = w.acc_z; acc[3] = w.acc_w;
    used = (att_used > SLOTS) ? SLOTS : att_used;
    for (int k = 0; k < used; k++) begin
      len2 = 0;
      for (int c = 0; c < 4; c++) begin
        comp = att_slot[k][16*c +: 16];
        att[c] = comp;
        ofs[c] = att[c] - pos[c];
        len2 += ofs[c] * ofs[c];
      end
      // attractor sitting on the particle adds nothing
      if (len2 != 0) begin
        strength = att[3];
        for (int c = 0; c < 4; c++)
          acc[c] = sat_acc(acc[c] + (ofs[c] * strength * 65536) / len2);
      end
    end
    r.new_acc_x = acc[0][31:0];
    r.new_acc_y = acc[1][31:0];
    r.new_acc_z = acc[2][31:0];
    r.new_acc_w = acc[3][31:0];
    r.frame_end = w.last_particle;
    return r;
  endfunction

  always @(posedge clk) begin
    out_word_t exp_w;
    out_word_t got;
    if (!rst_n) begin
      for (int k = 0; k < SLOTS; k++) att_slot[k] <= '0;
      att_used <= '0;
      acc_due.delete();
      fails <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        acc_due = {acc_due, attractor_pull(in_ch.data)};
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (acc_due.size() == 0) begin
          $display("%0t: unexpected result word %h", $time, got);
          fails <= fails + 1;
        end else begin
          exp_w = acc_due.pop_front();
          if (got !== exp_w) begin
            $display("%0t: mismatch x exp %h got %h | y exp %h got %h", $time,
                     exp_w.new_acc_x, got.new_acc_x, exp_w.new_acc_y, got.new_acc_y);
            $display("%0t:          z exp %h got %h | w exp %h got %h | end exp %b got %b",
                     $time, exp_w.new_acc_z, got.new_acc_z, exp_w.new_acc_w,
                     got.new_acc_w, exp_w.frame_end, got.frame_end);
            fails <= fails + 1;
          end
        end
      end
      // the user must change registers only while idle; this checker does not enforce it
      if (cfg_we) begin
        if (cfg_idx < SLOTS) att_slot[cfg_idx[1:0]] <= cfg_data;
        else if (cfg_idx == REG_ATT_COUNT) att_used <= cfg_data[COUNT_W-1:0];
      end
    end
  end

  assign pending = acc_due.size();

endmodule

/* sim/point_attractor_accel_test.sv */
`timescale 1ns / 100ps

module point_attractor_accel_test;
  import paa_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 50;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fails;
  int                    pending;
  int                    quiet_cycles;
  bit                    no_idle;
  int                    hold;

  logic [CFG_DATA_W-1:0] att_mirror [4];

  paa_in_if  in_ch ();
  paa_out_if out_ch ();

  point_attractor_accel uut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
    .cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch)
  );

  point_attractor_accel_check chk (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
    .cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch),
    .fails(fails), .pending(pending)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // result side back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold <= 0;
    end else if (hold > 0) begin
      out_ch.ready <= 1'b0;
      hold <= hold - 1;
    end else begin
      out_ch.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) hold <= gap_len();
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    if (idx < 4) att_mirror[idx[1:0]] = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_word(in_word_t w);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= w;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // drain the pipe before touching registers
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic in_word_t make_word(logic [15:0] px, logic [15:0] py,
                                         logic [15:0] pz, logic [15:0] pw,
                                         logic [31:0] acc, logic last);
    in_word_t w;
    w.pos_x = px; w.pos_y = py; w.pos_z = pz; w.pos_w = pw;
    w.acc_x = acc; w.acc_y = ~acc; w.acc_z = acc; w.acc_w = ~acc;
    w.last_particle = last;
    return w;
  endfunction

  function automatic logic [31:0] rand_acc();
    case ($urandom_range(0, 3))
      0: return 32'h7FFF_FFFF - $urandom_range(0, 255);
      1: return 32'h8000_0000 + $urandom_range(0, 255);
      2: return $urandom_range(0, 1023) - 512;
      default: return $urandom;
    endcase
  endfunction

  // mostly particles near an attractor, the rest anywhere
  function automatic in_word_t rand_word();
    in_word_t w;
    logic [CFG_DATA_W-1:0] a;
    logic [15:0] p [4];
    int spread;
    a = att_mirror[2'($urandom_range(0, 3))];
    spread = ($urandom_range(0, 1) == 0) ? 8 : 2048;
    for (int c = 0; c < 4; c++) begin
      if ($urandom_range(0, 3) == 0) p[c] = 16'($urandom);
      else p[c] = 16'(a[16*c +: 16] + $urandom_range(0, 2 * spread) - spread);
    end
    w.pos_x = p[0]; w.pos_y = p[1]; w.pos_z = p[2]; w.pos_w = p[3];
    w.acc_x = rand_acc(); w.acc_y = rand_acc();
    w.acc_z = rand_acc(); w.acc_w = rand_acc();
    w.last_particle = ($urandom_range(0, 7) == 0);
    return w;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_att(int style);
    logic [CFG_DATA_W-1:0] v;
    case (style)
      0: v = {4{16'h7FFF}};
      1: v = {4{16'h8000}};
      2: v = {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF};
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  initial begin
    int count_seq [8] = '{1, 2, 3, 4, 7, 0, 4, 5};
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    no_idle = 1'b0;
    for (int k = 0; k < 4; k++) att_mirror[k] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset state: no attractors in use
    send_word(make_word(16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 32'h7FFF_FFFF, 1'b1));
    send_word(make_word(16'h1234, 16'h8000, 16'h7FFF, 16'h0001, 32'h8000_0000, 1'b0));
    settle();

    // directed: attractor on the particle, extremes, count above slot total
    write_reg(CFG_IDX_W'(0), {16'h7FFF, 16'h0000, 16'h0000, 16'h0100});
    write_reg(CFG_IDX_W'(1), {4{16'h8000}});
    write_reg(CFG_IDX_W'(2), {4{16'h7FFF}});
    write_reg(CFG_IDX_W'(3), {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF});
    write_reg(REG_ATT_COUNT, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(CFG_IDX_W'(REG_ATT_COUNT + 1), '1);
    write_reg(CFG_IDX_W'(REG_ATT_COUNT + 3), '1);
    send_word(make_word(16'h0100, 16'h0000, 16'h0000, 16'h7FFF, 32'h0000_0000, 1'b0));
    send_word(make_word(16'h0100, 16'h0000, 16'h0000, 16'h7FFF, 32'h7FFF_FFFF, 1'b1));
    send_word(make_word(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'h8000_0000, 1'b0));
    send_word(make_word(16'h8000, 16'h8000, 16'h8000, 16'h8000, 32'h7FFF_FFFF, 1'b1));
    send_word(make_word(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 32'h0000_0001, 1'b0));
    send_word(make_word(16'h0101, 16'h0000, 16'h0000, 16'h7FFF, 32'hFFFF_FFFF, 1'b0));
    send_word(make_word(16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h8000_0000, 1'b1));
    send_word(make_word(16'h7FFE, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'h7FFF_FFFF, 1'b0));
    settle();

    // random phases over several register settings
    for (int ph = 0; ph < 8; ph++) begin
      for (int k = 0; k < 4; k++) write_reg(CFG_IDX_W'(k), rand_att((ph + k) % 5));
      write_reg(REG_ATT_COUNT, CFG_DATA_W'(count_seq[ph]));
      no_idle = (ph % 3 == 2);
      repeat (100) send_word(rand_word());
      settle();
    end

    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/paa_pkg.sv
hdl/paa_if.sv
hdl/paa_div.sv
hdl/point_attractor_accel.sv
hdl/paa_chk.sv
sim/point_attractor_accel_check.sv
sim/point_attractor_accel_test.sv
